// ===== hw/rtl/brpb_pkg.sv =====
// brpb_pkg: shared widths, register indices, sequencer states and divider
// request/response structs for the block row pointer builder.
// No dependencies.
package brpb_pkg;

   localparam int ROW_W     = 32;
   localparam int BLK_W     = 16;
   localparam int CNT_W     = 32;
   localparam int ENTRY_W   = ROW_W + 1;
   localparam int OUT_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 32;

   localparam int DIV_STEPS = ENTRY_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ROWS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECLARED_ROWS = 1'b1;

   localparam logic [ENTRY_W-1:0] ENTRY_LIMIT = {1'b0, {OUT_W{1'b1}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_BLOCK,
      ST_OPEN,
      ST_DIV_ROWS,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic               start;
      logic [ENTRY_W-1:0] dividend;
      logic [BLK_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ENTRY_W-1:0] quotient;
      logic               rem_nonzero;
   } div_rsp_type;

   function automatic logic [OUT_W-1:0] sat_entry(input logic [ENTRY_W-1:0] v);
      logic [ENTRY_W-1:0] s;
      s = (v > ENTRY_LIMIT) ? ENTRY_LIMIT : v;
      return s[OUT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/brpb_req_if.sv =====
// brpb_req_if: input channel carrying one nonzero item.
// Depends on brpb_pkg.
interface brpb_req_if import brpb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;
   logic             final_nonzero;

   modport source (output valid, output row_index, output final_nonzero, input ready);
   modport sink   (input valid, input row_index, input final_nonzero, output ready);
endinterface

// ===== hw/rtl/brpb_rsp_if.sv =====
// brpb_rsp_if: result channel carrying one pointer-range item.
// Depends on brpb_pkg.
interface brpb_rsp_if import brpb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] first_entry;
   logic [OUT_W-1:0] final_entry;
   logic [CNT_W-1:0] begin_offset;
   logic             array_done;

   modport source (output valid, output first_entry, output final_entry,
                   output begin_offset, output array_done, input ready);
   modport sink   (input valid, input first_entry, input final_entry,
                   input begin_offset, input array_done, output ready);
endinterface

// ===== hw/rtl/block_row_pointer_builder_top.sv =====
// Block row pointer builder: each item passes through the shared 33-step divider, an
// item that opens a range yields a range result, and a final item makes a second pass
// for the closing range. A new item is accepted only once the last one is finished. A
// result sits in an output register; a stalled result holds the sequencer until it is
// taken. Synchronous reset: block_rows and declared_rows to 1, count and next entry to
// zero, no item or result pending.
module block_row_pointer_builder_top import brpb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   brpb_req_if.sink             req_chan,
   brpb_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   state_type            state_ff, state_in;
   logic [BLK_W-1:0]     block_rows_ff;
   logic [ROW_W-1:0]     declared_rows_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ENTRY_W-1:0]   next_entry_ff, next_entry_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 last_ff, last_in;
   logic [ENTRY_W-1:0]   blk_ff, blk_in;

   logic                 out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]     out_first_ff, out_first_in;
   logic [OUT_W-1:0]     out_final_ff, out_final_in;
   logic [CNT_W-1:0]     out_offset_ff, out_offset_in;
   logic                 out_done_ff, out_done_in;

   logic [BLK_W-1:0]     block_size;
   logic [ENTRY_W-1:0]   row_plus1;
   logic [ENTRY_W-1:0]   rows;
   logic                 out_free;
   logic                 accept;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   brpb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign block_size = (block_rows_ff == '0) ? BLK_W'(1) : block_rows_ff;
   assign row_plus1  = {1'b0, row_ff} + ENTRY_W'(1);
   assign rows       = (row_plus1 > {1'b0, declared_rows_ff}) ? row_plus1
                                                               : {1'b0, declared_rows_ff};
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign accept     = req_chan.valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_entry_in = next_entry_ff;
      row_in        = row_ff;
      last_in       = last_ff;
      blk_in        = blk_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_first_in  = out_first_ff;
      out_final_in  = out_final_ff;
      out_offset_in = out_offset_ff;
      out_done_in   = out_done_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {1'b0, req_chan.row_index};
      div_req.divisor  = block_size;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in        = req_chan.row_index;
               last_in       = req_chan.final_nonzero;
               div_req.start = 1'b1;
               state_in      = ST_DIV_BLOCK;
            end
         end
         ST_DIV_BLOCK: begin
            if (div_rsp.done) begin
               blk_in = div_rsp.quotient;
               if (div_rsp.quotient >= next_entry_ff) begin
                  state_in = ST_OPEN;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (last_ff) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = rows;
                     state_in         = ST_DIV_ROWS;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_OPEN: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_first_in  = sat_entry(next_entry_ff);
               out_final_in  = sat_entry(blk_ff);
               out_offset_in = count_ff;
               out_done_in   = 1'b0;
               next_entry_in = blk_ff + 1'b1;
               count_in      = count_ff + 1'b1;
               if (last_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = rows;
                  state_in         = ST_DIV_ROWS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV_ROWS: begin
            if (div_rsp.done) begin
               blk_in   = div_rsp.quotient + ENTRY_W'(div_rsp.rem_nonzero);
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_first_in  = sat_entry(next_entry_ff);
               out_final_in  = sat_entry(blk_ff);
               out_offset_in = count_ff;
               out_done_in   = 1'b1;
               next_entry_in = '0;
               count_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
      end else begin
         state_ff         <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_rows_ff    <= BLK_W'(1);
         declared_rows_ff <= ROW_W'(1);
         count_ff         <= '0;
         next_entry_ff    <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_ROWS:    block_rows_ff    <= csr_wdata[BLK_W-1:0];
               CSR_DECLARED_ROWS: declared_rows_ff <= csr_wdata[ROW_W-1:0];
               default: ;
            endcase
         end
         count_ff      <= count_in;
         next_entry_ff <= next_entry_in;
         out_valid_ff  <= out_valid_in;
      end
      row_ff        <= row_in;
      last_ff       <= last_in;
      blk_ff        <= blk_in;
      out_first_ff  <= out_first_in;
      out_final_ff  <= out_final_in;
      out_offset_ff <= out_offset_in;
      out_done_ff   <= out_done_in;
   end

   assign req_chan.ready        = state_ff == ST_IDLE;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.first_entry  = out_first_ff;
   assign rsp_chan.final_entry  = out_final_ff;
   assign rsp_chan.begin_offset = out_offset_ff;
   assign rsp_chan.array_done   = out_done_ff;

endmodule

// ===== hw/rtl/brpb_div.sv =====
// brpb_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on brpb_pkg (div_req_type, div_rsp_type, widths).
module brpb_div import brpb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ENTRY_W-1:0]   quo_ff, quo_in;
   logic [BLK_W-1:0]     rem_ff, rem_in;
   logic [BLK_W-1:0]     divisor_ff, divisor_in;
   logic [BLK_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[ENTRY_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(DIV_STEPS - 1);
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? BLK_W'(trial - {1'b0, divisor_ff}) : trial[BLK_W-1:0];
         quo_in = {quo_ff[ENTRY_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done        = done_ff;
   assign div_rsp.quotient    = quo_ff;
   assign div_rsp.rem_nonzero = rem_ff != '0;

endmodule
